>>> rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stuffed frame receiver core.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int ADDR_W       = IDX_W + 1;
    localparam int RAM_DEPTH    = 2 ** ADDR_W;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int HDR_LEN      = 5;

    localparam logic [7:0] MARK_START = 8'hFE;
    localparam logic [7:0] MARK_END   = 8'hFF;
    localparam logic [7:0] FLAGS_MASK = 8'h07;
    localparam logic [7:0] MSGID_MASK = 8'h1F;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             ovf;
        logic [7:0]       hdr0;
        logic [7:0]       hdr1;
        logic [7:0]       hdr2;
        logic [7:0]       hdr3;
        logic [7:0]       hdr4;
    } t_job;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_LOAD,
        B_HOLD
    } t_back_state;

    typedef struct packed {
        logic pop;
        logic rd_en;
        logic load_data;
        logic done;
    } t_back_ctl;

endpackage

>>> rtl/core/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sfr_job_fifo.sv
// ----------------------------------------------------------------------------
// sfr_job_fifo
// Two-entry queue of completed frames between the front and back ends.
// ----------------------------------------------------------------------------
module sfr_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfr_pkg::t_job i_job,
    input  logic          i_pop,
    output sfr_pkg::t_job o_job,
    output logic          o_empty,
    output logic [1:0]    o_level
);

    sfr_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 2'd1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 2'd1;
            end
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_empty = (r_level == 2'd0);
    assign o_level = r_level;

endmodule

>>> rtl/core/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Marker decoder: tracks framing state, fills the packet store, queues frames.
// ----------------------------------------------------------------------------
module sfr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rx_valid,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_room,
    output logic             o_rx_ready,
    output sfr_pkg::t_ram_wr o_wr,
    output logic             o_push,
    output sfr_pkg::t_job    o_job
);

    logic                      r_start_pend;
    logic                      r_end_pend;
    logic                      r_in_pkt;
    logic [sfr_pkg::CNT_W-1:0] r_count;
    logic                      r_ovf;
    logic                      r_bank;
    logic [7:0]                r_hdr [sfr_pkg::HDR_LEN];

    logic                      n_start_pend;
    logic                      n_end_pend;
    logic                      n_in_pkt;
    logic                      accept;
    logic                      push;
    logic                      clr;
    logic                      emit;
    logic                      ip_now;
    logic [sfr_pkg::CNT_W-1:0] cnt_base;
    logic                      fits;

    assign o_rx_ready = i_room;
    assign accept     = i_rx_valid && i_room;

    always_comb begin
        push         = 1'b0;
        clr          = 1'b0;
        emit         = 1'b0;
        ip_now       = r_in_pkt;
        n_start_pend = r_start_pend;
        n_end_pend   = r_end_pend;
        n_in_pkt     = r_in_pkt;
        priority if (i_rx_byte == sfr_pkg::MARK_START) begin
            if (r_start_pend) begin
                if (r_in_pkt) begin
                    push         = 1'b1;
                    n_start_pend = 1'b0;
                end
            end else if (r_end_pend) begin
                if (r_in_pkt) begin
                    emit     = 1'b1;
                    n_in_pkt = 1'b0;
                end
            end else begin
                n_start_pend = 1'b1;
            end
            n_end_pend = 1'b0;
        end else if (i_rx_byte == sfr_pkg::MARK_END) begin
            ip_now   = r_in_pkt | r_start_pend;
            n_in_pkt = ip_now;
            if (r_end_pend) begin
                if (ip_now) begin
                    push       = 1'b1;
                    n_end_pend = 1'b0;
                end
            end else begin
                n_end_pend = 1'b1;
            end
            n_start_pend = 1'b0;
        end else begin
            if (r_start_pend) begin
                clr          = 1'b1;
                n_start_pend = 1'b0;
                ip_now       = 1'b1;
            end else if (r_end_pend) begin
                clr        = 1'b1;
                n_end_pend = 1'b0;
                ip_now     = 1'b0;
            end
            n_in_pkt = ip_now;
            push     = ip_now;
        end
    end

    assign cnt_base = clr ? '0 : r_count;
    assign fits     = (cnt_base < sfr_pkg::CNT_W'(sfr_pkg::BUFFER_DEPTH));

    assign o_wr.we   = accept && push && fits;
    assign o_wr.addr = {r_bank, cnt_base[sfr_pkg::IDX_W-1:0]};
    assign o_wr.data = i_rx_byte;

    assign o_push     = accept && emit;
    assign o_job.bank  = r_bank;
    assign o_job.count = r_count;
    assign o_job.ovf   = r_ovf;
    assign o_job.hdr0  = r_hdr[0];
    assign o_job.hdr1  = r_hdr[1];
    assign o_job.hdr2  = r_hdr[2];
    assign o_job.hdr3  = r_hdr[3];
    assign o_job.hdr4  = r_hdr[4];

    always_ff @(posedge i_clk) begin
        if (accept && push) begin
            for (int i = 0; i < sfr_pkg::HDR_LEN; i++) begin
                if (cnt_base == sfr_pkg::CNT_W'(i)) begin
                    r_hdr[i] <= i_rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pend <= 1'b0;
            r_end_pend   <= 1'b0;
            r_in_pkt     <= 1'b0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_bank       <= 1'b0;
        end else if (accept) begin
            r_start_pend <= n_start_pend;
            r_end_pend   <= n_end_pend;
            r_in_pkt     <= n_in_pkt;
            if (emit) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_bank  <= ~r_bank;
            end else if (push) begin
                if (fits) begin
                    r_count <= cnt_base + sfr_pkg::CNT_W'(1);
                    r_ovf   <= clr ? 1'b0 : r_ovf;
                end else begin
                    r_count <= cnt_base;
                    r_ovf   <= 1'b1;
                end
            end else if (clr) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Result sequencer: splits a queued frame into its run of result transfers.
// ----------------------------------------------------------------------------
module sfr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_empty,
    input  sfr_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_rd_en,
    output logic [sfr_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output logic                       o_busy,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [2:0]                 o_flags,
    output logic [4:0]                 o_message_id,
    output logic [7:0]                 o_target_service,
    output logic [7:0]                 o_source_service,
    output logic [7:0]                 o_packet_id,
    output logic [7:0]                 o_check_byte,
    output logic [7:0]                 o_data_byte,
    output logic                       o_data_valid,
    output logic                       o_last,
    output logic [1:0]                 o_status
);

    sfr_pkg::t_back_state      r_state;
    sfr_pkg::t_back_state      n_state;
    sfr_pkg::t_back_ctl        ctl;
    logic                      r_bank;
    logic [sfr_pkg::CNT_W-1:0] r_count;
    logic [sfr_pkg::CNT_W-1:0] r_idx;
    logic                      r_valid;
    logic [2:0]                r_flags;
    logic [4:0]                r_message_id;
    logic [7:0]                r_target_service;
    logic [7:0]                r_source_service;
    logic [7:0]                r_packet_id;
    logic [7:0]                r_check_byte;
    logic [7:0]                r_data_byte;
    logic                      r_data_valid;
    logic                      r_last;
    logic [1:0]                r_status;
    logic                      head_short;
    logic                      head_long;

    assign head_short = (i_job.count < sfr_pkg::CNT_W'(sfr_pkg::HDR_LEN));
    assign head_long  = (i_job.count > sfr_pkg::CNT_W'(sfr_pkg::HDR_LEN));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfr_pkg::B_IDLE: begin
                if (!i_job_empty) begin
                    n_state = head_long ? sfr_pkg::B_FETCH : sfr_pkg::B_HOLD;
                end
            end
            sfr_pkg::B_FETCH: n_state = sfr_pkg::B_LOAD;
            sfr_pkg::B_LOAD:  n_state = sfr_pkg::B_HOLD;
            sfr_pkg::B_HOLD: begin
                if (i_res_ready) begin
                    n_state = r_last ? sfr_pkg::B_IDLE : sfr_pkg::B_FETCH;
                end
            end
            default: n_state = sfr_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (r_state)
            sfr_pkg::B_IDLE:  ctl.pop       = !i_job_empty;
            sfr_pkg::B_FETCH: ctl.rd_en     = 1'b1;
            sfr_pkg::B_LOAD:  ctl.load_data = 1'b1;
            sfr_pkg::B_HOLD:  ctl.done      = i_res_ready;
            default: ctl = '0;
        endcase
    end

    assign o_pop     = ctl.pop;
    assign o_rd_en   = ctl.rd_en;
    assign o_rd_addr = {r_bank, r_idx[sfr_pkg::IDX_W-1:0]};
    assign o_busy    = (r_state != sfr_pkg::B_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (n_state == sfr_pkg::B_HOLD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.pop) begin
            r_bank  <= i_job.bank;
            r_count <= i_job.count;
            r_idx   <= sfr_pkg::CNT_W'(sfr_pkg::HDR_LEN);
            r_data_byte  <= 8'd0;
            r_data_valid <= 1'b0;
            r_last       <= 1'b1;
            if (head_short) begin
                r_flags          <= 3'd0;
                r_message_id     <= 5'd0;
                r_target_service <= 8'd0;
                r_source_service <= 8'd0;
                r_packet_id      <= 8'd0;
                r_check_byte     <= 8'd0;
                r_status         <= sfr_pkg::ST_SHORT;
            end else begin
                r_flags          <= 3'(i_job.hdr0 & sfr_pkg::FLAGS_MASK);
                r_message_id     <= 5'(i_job.hdr0 & sfr_pkg::MSGID_MASK);
                r_target_service <= i_job.hdr1;
                r_source_service <= i_job.hdr2;
                r_packet_id      <= i_job.hdr3;
                r_check_byte     <= i_job.hdr4;
                r_status         <= i_job.ovf ? sfr_pkg::ST_OVF : sfr_pkg::ST_OK;
            end
        end
        if (ctl.load_data) begin
            r_data_byte  <= i_rd_data;
            r_data_valid <= 1'b1;
            r_last       <= (r_idx + sfr_pkg::CNT_W'(1) == r_count);
        end
        if (ctl.done && !r_last) begin
            r_idx <= r_idx + sfr_pkg::CNT_W'(1);
        end
    end

    assign o_res_valid      = r_valid;
    assign o_flags          = r_flags;
    assign o_message_id     = r_message_id;
    assign o_target_service = r_target_service;
    assign o_source_service = r_source_service;
    assign o_packet_id      = r_packet_id;
    assign o_check_byte     = r_check_byte;
    assign o_data_byte      = r_data_byte;
    assign o_data_valid     = r_data_valid;
    assign o_last           = r_last;
    assign o_status         = r_status;

endmodule

>>> rtl/core/stuffed_frame_receiver_core.sv
// Result path: a frame-ending byte queues its frame; the sequencer pops it into HOLD
// for a header-only or short frame, or via FETCH and LOAD when it carries data.
// Throughput: one byte per cycle while fewer than two frames are queued or in the
// result sequencer; each data result is read from the single packet-store read port.
// Reset: synchronous, active low; clears framing flags, counts and queues, not the store.
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_core
// Byte-stuffed frame receiver: marker decoder, frame queue, result sequencer.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_flags,
    output logic [4:0] o_message_id,
    output logic [7:0] o_target_service,
    output logic [7:0] o_source_service,
    output logic [7:0] o_packet_id,
    output logic [7:0] o_check_byte,
    output logic [7:0] o_data_byte,
    output logic       o_data_valid,
    output logic       o_last,
    output logic [1:0] o_status
);

    sfr_pkg::t_ram_wr           wr;
    sfr_pkg::t_job              push_job;
    sfr_pkg::t_job              head_job;
    logic                       push;
    logic                       pop;
    logic                       empty;
    logic [1:0]                 level;
    logic                       busy;
    logic                       room;
    logic                       rd_en;
    logic [sfr_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                 rd_data;

    // hold input while both store banks are owned by queued or active frames
    assign room = (level == 2'd0) || ((level == 2'd1) && !busy);

    sfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .i_room     (room),
        .o_rx_ready (o_rx_ready),
        .o_wr       (wr),
        .o_push     (push),
        .o_job      (push_job)
    );

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (sfr_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    sfr_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty),
        .o_level (level)
    );

    sfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_empty      (empty),
        .i_job            (head_job),
        .o_pop            (pop),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data),
        .o_busy           (busy),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_flags          (o_flags),
        .o_message_id     (o_message_id),
        .o_target_service (o_target_service),
        .o_source_service (o_source_service),
        .o_packet_id      (o_packet_id),
        .o_check_byte     (o_check_byte),
        .o_data_byte      (o_data_byte),
        .o_data_valid     (o_data_valid),
        .o_last           (o_last),
        .o_status         (o_status)
    );

`ifndef SYNTH
    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (level != 2'd2))
        else $error("frame queued with no free slot");

    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("frame taken from empty queue");

    a_short_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_status == sfr_pkg::ST_SHORT)) |-> (o_last && !o_data_valid))
        else $error("short frame result not a lone empty transfer");

    a_bank_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.we && busy) |-> (wr.addr[sfr_pkg::ADDR_W-1] != rd_addr[sfr_pkg::ADDR_W-1]))
        else $error("store bank written while being read");
`endif

endmodule

>>> bench/tb_stuffed_frame_receiver_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stuffed_frame_receiver_core
// Streams byte-stuffed serial traffic into the receiver core: a short table
// of framing corner cases, then random frames, noise and cut-off frames under
// random sender gaps and receiver stalls. Every result transfer is compared
// field by field against a frame decoder kept inside the bench.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_receiver_core;

    typedef struct packed {
        logic [2:0] flags;
        logic [4:0] message_id;
        logic [7:0] target_service;
        logic [7:0] source_service;
        logic [7:0] packet_id;
        logic [7:0] check_byte;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last;
        logic [1:0] status;
    } t_frame_result;

    typedef struct packed {
        logic [7:0]    rx;
        logic          typed;
        t_frame_result res;
    } t_stim_row;

    localparam t_frame_result NO_RES    = '0;
    localparam t_frame_result SHORT_RES = {3'd0, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                                           8'h00, 1'b0, 1'b1, sfr_pkg::ST_SHORT};
    localparam t_frame_result EMPTY_RES = {3'd7, 5'h1F, 8'hFE, 8'h00, 8'h7F, 8'h80,
                                           8'h00, 1'b0, 1'b1, sfr_pkg::ST_OK};
    localparam int DIR_LEN    = 31;
    localparam int BULK_ITEMS = 110;
    localparam int HOLD_OFF   = 400;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_res_valid;
    logic [2:0] o_flags;
    logic [4:0] o_message_id;
    logic [7:0] o_target_service;
    logic [7:0] o_source_service;
    logic [7:0] o_packet_id;
    logic [7:0] o_check_byte;
    logic [7:0] o_data_byte;
    logic       o_data_valid;
    logic       o_last;
    logic [1:0] o_status;

    stuffed_frame_receiver_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_flags          (o_flags),
        .o_message_id     (o_message_id),
        .o_target_service (o_target_service),
        .o_source_service (o_source_service),
        .o_packet_id      (o_packet_id),
        .o_check_byte     (o_check_byte),
        .o_data_byte      (o_data_byte),
        .o_data_valid     (o_data_valid),
        .o_last           (o_last),
        .o_status         (o_status)
    );

    always #1 i_clk = ~i_clk;

    // frame decoder state
    logic          seen_start;
    logic          seen_end;
    logic          framing;
    logic [7:0]    frame_buf [0:sfr_pkg::BUFFER_DEPTH-1];
    int            frame_len;
    logic          frame_ovf;
    t_frame_result due_results [$];
    int            queued_total = 0;

    int   fail_count  = 0;
    int   sent_bytes  = 0;
    int   burst_left  = 0;
    logic bulk_phase  = 1'b0;
    logic held_off    = 1'b0;
    int   stall_cyc   = 0;
    logic [7:0] ready_pat = 8'hFF;

    t_stim_row dir_rows [0:DIR_LEN-1] = '{
        // short frame
        {8'hFE, 1'b0, NO_RES}, {8'h12, 1'b0, NO_RES}, {8'hFF, 1'b0, NO_RES},
        {8'hFE, 1'b1, SHORT_RES},
        // end outside a frame
        {8'hFF, 1'b0, NO_RES}, {8'hFE, 1'b0, NO_RES},
        // lone end marker
        {8'hFE, 1'b0, NO_RES}, {8'h34, 1'b0, NO_RES}, {8'hFF, 1'b0, NO_RES},
        {8'h56, 1'b0, NO_RES},
        // doubled start outside, start then end, stuffed markers, empty payload
        {8'hFE, 1'b0, NO_RES}, {8'hFE, 1'b0, NO_RES}, {8'hFF, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES}, {8'hFE, 1'b0, NO_RES}, {8'hFE, 1'b0, NO_RES},
        {8'h00, 1'b0, NO_RES}, {8'h7F, 1'b0, NO_RES}, {8'h80, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES}, {8'hFE, 1'b1, EMPTY_RES},
        // frame with one data byte
        {8'hFE, 1'b0, NO_RES}, {8'h41, 1'b0, NO_RES}, {8'hFF, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES}, {8'h00, 1'b0, NO_RES}, {8'h01, 1'b0, NO_RES},
        {8'h02, 1'b0, NO_RES}, {8'h80, 1'b0, NO_RES}, {8'hFF, 1'b0, NO_RES},
        {8'hFE, 1'b0, NO_RES}
    };

    function automatic void add_due(input t_frame_result r);
        due_results.insert(due_results.size(), r);
        queued_total++;
    endfunction

    function automatic void push_frame_byte(input logic [7:0] b);
        if (frame_len < sfr_pkg::BUFFER_DEPTH) begin
            frame_buf[frame_len] = b;
            frame_len++;
        end else begin
            frame_ovf = 1'b1;
        end
    endfunction

    function automatic void decode_serial_byte(input logic [7:0] b);
        t_frame_result r;
        int            nres;
        if (b == sfr_pkg::MARK_START) begin
            if (seen_start) begin
                if (framing) begin
                    push_frame_byte(b);
                    seen_start = 1'b0;
                end
            end else if (seen_end) begin
                if (framing) begin
                    if (frame_len < sfr_pkg::HDR_LEN) begin
                        add_due(SHORT_RES);
                    end else begin
                        nres = (frame_len == sfr_pkg::HDR_LEN) ? 1
                                                               : frame_len - sfr_pkg::HDR_LEN;
                        for (int k = 0; k < nres; k++) begin
                            r.flags          = 3'(frame_buf[0] & sfr_pkg::FLAGS_MASK);
                            r.message_id     = 5'(frame_buf[0] & sfr_pkg::MSGID_MASK);
                            r.target_service = frame_buf[1];
                            r.source_service = frame_buf[2];
                            r.packet_id      = frame_buf[3];
                            r.check_byte     = frame_buf[4];
                            r.data_valid     = (sfr_pkg::HDR_LEN + k) < frame_len;
                            r.data_byte      = r.data_valid ? frame_buf[sfr_pkg::HDR_LEN + k]
                                                            : 8'h00;
                            r.last           = (k == nres - 1);
                            r.status         = frame_ovf ? sfr_pkg::ST_OVF : sfr_pkg::ST_OK;
                            add_due(r);
                        end
                    end
                    frame_len = 0;
                    frame_ovf = 1'b0;
                    framing   = 1'b0;
                end
            end else begin
                seen_start = 1'b1;
            end
            seen_end = 1'b0;
        end else if (b == sfr_pkg::MARK_END) begin
            if (seen_start) begin
                framing = 1'b1;
            end
            if (seen_end) begin
                if (framing) begin
                    push_frame_byte(b);
                    seen_end = 1'b0;
                end
            end else begin
                seen_end = 1'b1;
            end
            seen_start = 1'b0;
        end else begin
            if (seen_start) begin
                frame_len  = 0;
                frame_ovf  = 1'b0;
                seen_start = 1'b0;
                framing    = 1'b1;
            end else if (seen_end) begin
                frame_len = 0;
                frame_ovf = 1'b0;
                seen_end  = 1'b0;
                framing   = 1'b0;
            end
            if (framing) begin
                push_frame_byte(b);
            end
        end
    endfunction

    function automatic logic [7:0] line_byte();
        if ($urandom_range(0, 4) == 0) begin
            return $urandom_range(0, 1) ? sfr_pkg::MARK_START : sfr_pkg::MARK_END;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        sent_bytes++;
        decode_serial_byte(b);
    endtask

    task automatic send_frame(input int len);
        logic [7:0] b;
        send_byte(sfr_pkg::MARK_START);
        for (int i = 0; i < len; i++) begin
            b = (i == 0) ? 8'($urandom_range(0, 253)) : line_byte();
            send_byte(b);
            if (b == sfr_pkg::MARK_START || b == sfr_pkg::MARK_END) begin
                send_byte(b);
            end
        end
        send_byte(sfr_pkg::MARK_END);
        send_byte(sfr_pkg::MARK_START);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result w;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (due_results.size() == 0) begin
                $error("result transfer with nothing outstanding");
                fail_count++;
            end else begin
                w = due_results.pop_front();
                check_field("flags", 8'(w.flags), 8'(o_flags));
                check_field("message_id", 8'(w.message_id), 8'(o_message_id));
                check_field("target_service", w.target_service, o_target_service);
                check_field("source_service", w.source_service, o_source_service);
                check_field("packet_id", w.packet_id, o_packet_id);
                check_field("check_byte", w.check_byte, o_check_byte);
                check_field("data_byte", w.data_byte, o_data_byte);
                check_field("data_valid", 8'(w.data_valid), 8'(o_data_valid));
                check_field("last", 8'(w.last), 8'(o_last));
                check_field("status", 8'(w.status), 8'(o_status));
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off at the start of the random traffic
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (bulk_phase && !held_off) begin
                held_off = 1'b1;
                i_res_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else begin
                if (stall_cyc % 32 == 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_pat = 8'hFF;
                        1: ready_pat = 8'($urandom_range(0, 255));
                        2: ready_pat = 8'h01;
                        default: ready_pat = 8'hAA;
                    endcase
                end
                i_res_ready <= ready_pat[stall_cyc % 8];
                stall_cyc++;
            end
        end
    end

    initial begin
        int n;
        int pick;
        seen_start = 1'b0;
        seen_end   = 1'b0;
        framing    = 1'b0;
        frame_len  = 0;
        frame_ovf  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_LEN; i++) begin
            n = queued_total;
            send_byte(dir_rows[i].rx);
            if (dir_rows[i].typed) begin
                repeat (queued_total - n) void'(due_results.pop_back());
                due_results.insert(due_results.size(), dir_rows[i].res);
            end
        end

        bulk_phase = 1'b1;
        send_frame(66);
        while (sent_bytes < DIR_LEN + BULK_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                repeat ($urandom_range(1, 6)) send_byte(line_byte());
            end else if (pick == 3) begin
                send_frame($urandom_range(60, 70));
            end else if (pick == 4) begin
                // drop the frame end
                send_byte(sfr_pkg::MARK_START);
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 253)));
            end else begin
                send_frame($urandom_range(0, 12));
            end
        end
        i_rx_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
